// ----- hw/rtl/session_replay_counter_table_top_defines.svh -----
// ----------------------------------------------------------------------------
// session replay counter table: assertion macros
// Shared concurrent assertion shorthands, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SESSION_REPLAY_COUNTER_TABLE_TOP_DEFINES_SVH
`define SESSION_REPLAY_COUNTER_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define SRCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srct assertion failed");

// next-cycle implication
`define SRCT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srct assertion failed");

`endif

// ----- hw/rtl/srct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srct_pkg
// Types and constants shared by the replay counter table cells and top level.
// ----------------------------------------------------------------------------
package srct_pkg;

    localparam int SESSION_SLOTS = 8;
    localparam int SID_W         = 16;
    localparam int CNT_W         = 32;
    localparam int OUTCOME_W     = 3;

    localparam logic [SID_W-1:0] SID_UNSECURED = '0;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_UNSECURED = 3'd0,
        OUTCOME_ADVANCED  = 3'd1,
        OUTCOME_REPLAY    = 3'd2,
        OUTCOME_NEW       = 3'd3,
        OUTCOME_FULL      = 3'd4
    } outcome_t;

    // lookup token walking down the cell row
    typedef struct packed {
        logic             valid;
        logic [SID_W-1:0] sid;
        logic [CNT_W-1:0] cnt;
        logic             done;
        outcome_t         outcome;
    } token_t;

endpackage

// ----- hw/rtl/srct_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srct_cell
// One table entry: holds a session and its last counter, checks or claims
// the passing lookup token and hands it, registered, to the next cell.
// ----------------------------------------------------------------------------
module srct_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  srct_pkg::token_t  tok_in,
    output srct_pkg::token_t  tok_out
);

    logic                        in_use_reg;
    logic                        in_use_next;
    logic [srct_pkg::SID_W-1:0]  session_reg;
    logic [srct_pkg::SID_W-1:0]  session_next;
    logic [srct_pkg::CNT_W-1:0]  count_reg;
    logic [srct_pkg::CNT_W-1:0]  count_next;
    srct_pkg::token_t            tok_reg;
    srct_pkg::token_t            tok_next;
    logic                        live;
    logic                        match;
    logic                        claim;
    logic                        advance;

    // match against a live entry, or claim this entry when it is free
    always_comb
    begin
        live    = tok_in.valid && !tok_in.done;
        match   = live && in_use_reg && (session_reg == tok_in.sid);
        claim   = live && !in_use_reg;
        advance = match && (tok_in.cnt > count_reg);
    end

    // token update
    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            tok_next.done    = 1'b1;
            tok_next.outcome = advance ? srct_pkg::OUTCOME_ADVANCED
                                       : srct_pkg::OUTCOME_REPLAY;
        end
        else if (claim)
        begin
            tok_next.done    = 1'b1;
            tok_next.outcome = srct_pkg::OUTCOME_NEW;
        end
    end

    // entry update
    always_comb
    begin
        in_use_next  = in_use_reg || claim;
        session_next = claim ? tok_in.sid : session_reg;
        count_next   = (claim || advance) ? tok_in.cnt : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= 1'b0;
            session_reg <= '0;
            count_reg   <= '0;
            tok_reg     <= '0;
        end
        else
        begin
            in_use_reg  <= in_use_next;
            session_reg <= session_next;
            count_reg   <= count_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- hw/rtl/session_replay_counter_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_replay_counter_table_top
// Per-session message counter replay check built as a row of table cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid / in_stall | session, msg_count
//  out     | from block| out_valid/out_stall | accepted, outcome
//
//  a request walks the row of SESSION_SLOTS cells, one cell per cycle, and its
//  result then passes through the pending stage into the output register.
//  one request is in the row at a time; the next one is taken as soon as the
//  previous result has left the pending stage, even while out is stalled.
//  reset clears every entry at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "session_replay_counter_table_top_defines.svh"

module session_replay_counter_table_top #(
    parameter int SESSION_SLOTS = srct_pkg::SESSION_SLOTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [srct_pkg::SID_W-1:0]        session,
    input  logic [srct_pkg::CNT_W-1:0]        msg_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              accepted,
    output logic [srct_pkg::OUTCOME_W-1:0]    outcome
);

    srct_pkg::token_t     tok [SESSION_SLOTS+1];
    logic [SESSION_SLOTS:0] tok_valid_vec;
    logic                 in_take;
    logic                 pend_move;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    srct_pkg::outcome_t   pend_outcome_reg;
    srct_pkg::outcome_t   pend_outcome_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    srct_pkg::outcome_t   out_outcome_reg;
    srct_pkg::outcome_t   out_outcome_next;

    assign in_stall = busy_reg;
    assign in_take  = in_valid && !busy_reg;

    // head token; the unsecured session is settled before the row
    always_comb
    begin
        tok[0].valid   = in_take;
        tok[0].sid     = session;
        tok[0].cnt     = msg_count;
        tok[0].done    = (session == srct_pkg::SID_UNSECURED);
        tok[0].outcome = srct_pkg::OUTCOME_UNSECURED;
    end

    // row of table cells
    for (genvar i = 0; i < SESSION_SLOTS; i++)
    begin : g_cell
        srct_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    for (genvar j = 0; j <= SESSION_SLOTS; j++)
    begin : g_vld
        assign tok_valid_vec[j] = tok[j].valid;
    end

    assign pend_move = pend_valid_reg && (!out_valid_reg || !out_stall);

    // pending stage, output register and busy flag
    always_comb
    begin
        busy_next         = busy_reg;
        pend_valid_next   = pend_valid_reg;
        pend_outcome_next = pend_outcome_reg;
        out_valid_next    = out_valid_reg;
        out_outcome_next  = out_outcome_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_move)
        begin
            out_valid_next   = 1'b1;
            out_outcome_next = pend_outcome_reg;
            pend_valid_next  = 1'b0;
            busy_next        = 1'b0;
        end
        // token leaving the row without a decision found the table full
        if (tok[SESSION_SLOTS].valid)
        begin
            pend_valid_next   = 1'b1;
            pend_outcome_next = tok[SESSION_SLOTS].done ? tok[SESSION_SLOTS].outcome
                                                        : srct_pkg::OUTCOME_FULL;
        end
        if (in_take)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        pend_outcome_reg <= pend_outcome_next;
        out_outcome_reg  <= out_outcome_next;
    end

    assign out_valid = out_valid_reg;
    assign outcome   = out_outcome_reg;
    assign accepted  = (out_outcome_reg != srct_pkg::OUTCOME_REPLAY);

    // checks
    `SRCT_ASSERT_IMP(a_one_token, 1'b1, $countones(tok_valid_vec) <= 1)
    `SRCT_ASSERT_NXT(a_take_busy, in_valid && !in_stall, busy_reg)
    `SRCT_ASSERT_NXT(a_pend_drain, pend_valid_reg && !out_valid_reg, out_valid_reg && !pend_valid_reg)

endmodule
